>>> design/z80_increment_unit_assert.svh
// assertion macros used by the z80 increment unit checker
`ifndef Z80_INCREMENT_UNIT_ASSERT_SVH
`define Z80_INCREMENT_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define Z80INC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("z80inc implication check failed");

// next-cycle implication under reset
`define Z80INC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("z80inc next-cycle check failed");

`endif

>>> design/z80inc_pkg.sv
// constants shared by the z80 increment unit
package z80inc_pkg;

  // register file word layout
  localparam int RF_DEPTH = 8;
  localparam int RF_AW    = 3;
  localparam int RF_DW    = 16;

  localparam logic [RF_AW-1:0] ENT_BC = 3'd0;
  localparam logic [RF_AW-1:0] ENT_DE = 3'd1;
  localparam logic [RF_AW-1:0] ENT_HL = 3'd2;
  localparam logic [RF_AW-1:0] ENT_A  = 3'd3;
  localparam logic [RF_AW-1:0] ENT_SP = 3'd4;
  localparam logic [RF_AW-1:0] ENT_IX = 3'd5;
  localparam logic [RF_AW-1:0] ENT_IY = 3'd6;
  localparam logic [RF_AW-1:0] ENT_WZ = 3'd7;

  // instruction forms
  localparam logic [2:0] KIND_REG8  = 3'd0;
  localparam logic [2:0] KIND_HL    = 3'd1;
  localparam logic [2:0] KIND_IXD   = 3'd2;
  localparam logic [2:0] KIND_IYD   = 3'd3;
  localparam logic [2:0] KIND_PAIR  = 3'd4;
  localparam logic [2:0] KIND_IX    = 3'd5;
  localparam logic [2:0] KIND_IY    = 3'd6;
  localparam logic [2:0] KIND_NONE  = 3'd7;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam logic [1:0] PAIR_SP    = 2'd3;

  // t-state counts
  localparam logic [4:0] T_REG8  = 5'd4;
  localparam logic [4:0] T_HL    = 5'd11;
  localparam logic [4:0] T_INDEX = 5'd23;
  localparam logic [4:0] T_PAIR  = 5'd6;
  localparam logic [4:0] T_IDX16 = 5'd10;

endpackage

>>> design/z80inc_if.sv
// request and result channels of the z80 increment unit
interface z80inc_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [2:0]        reg_select;
  logic [1:0]        pair_select;
  logic signed [7:0] displacement;
  logic [7:0]        mem_data;

  modport source (output valid, kind, reg_select, pair_select, displacement, mem_data,
                  input ready);
  modport sink (input valid, kind, reg_select, pair_select, displacement, mem_data,
                output ready);
endinterface

interface z80inc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mem_address;
  logic        mem_write;
  logic [7:0]  write_data;
  logic [7:0]  flag_byte;
  logic [4:0]  t_states;

  modport source (output valid, mem_address, mem_write, write_data, flag_byte, t_states,
                  input ready);
  modport sink (input valid, mem_address, mem_write, write_data, flag_byte, t_states,
                output ready);
endinterface

>>> design/z80inc_ram.sv
// generic single-port-write ram with registered read
module z80inc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/z80_increment_unit.sv
// z80 inc instruction unit: register file ram, execute stage and result register
//
//   channel  | port    | direction | moves
//   ---------+---------+-----------+--------------------------------------------
//   request  | in_chan | sink      | kind, reg_select, pair_select, disp, data
//   result   | out_chan| source    | address, write strobe, data, flags, t-states
//
// one request per cycle sustained while out_chan is ready; a request reads the ram at
// acceptance, then executes and writes back as it enters the result register
// the register file ram has one read and one write port; a write lands on the same
// edge as the next request's ram read, so the last write is forwarded
// reset is synchronous; ram entries read as zero until first written
// a stalled result holds the execute stage, which then drops in_chan.ready
module z80_increment_unit
  import z80inc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  z80inc_in_if.sink  in_chan,
  z80inc_out_if.source out_chan
);

  // ram words: BC DE HL -A SP IX IY WZ; F lives in its own register
  logic [RF_AW-1:0] rd_addr;
  logic             rd_en;
  logic [RF_DW-1:0] ram_rdata;
  logic             wr_en;
  logic [RF_AW-1:0] wr_addr;
  logic [RF_DW-1:0] wr_data;

  // written-once bits stand in for the all-zero reset of the ram
  logic [RF_DEPTH-1:0] wvld_r;
  logic                rd_vld_r;

  // last write, forwarded to the execute stage
  logic             fwd_vld_r;
  logic [RF_AW-1:0] fwd_addr_r;
  logic [RF_DW-1:0] fwd_data_r;

  // execute stage
  logic              s1_valid_r;
  logic [2:0]        s1_kind_r;
  logic [2:0]        s1_rsel_r;
  logic [RF_AW-1:0]  s1_addr_r;
  logic [7:0]        s1_disp_r;
  logic [7:0]        s1_data_r;
  logic              s1_adv;
  logic              s1_fire;

  logic [7:0]        flag_r;

  // result register
  logic        out_valid_r;
  logic [15:0] out_addr_r;
  logic        out_wr_r;
  logic [7:0]  out_wdata_r;
  logic [7:0]  out_flag_r;
  logic [4:0]  out_ts_r;

  // execute results
  logic [RF_DW-1:0] word_ram;
  logic [RF_DW-1:0] word;
  logic [7:0]       inc_src;
  logic [7:0]       inc_res;
  logic [7:0]       flag_inc;
  logic             is8;
  logic             ram_wen;
  logic [RF_AW-1:0] ram_waddr;
  logic [RF_DW-1:0] ram_wdata;
  logic [15:0]      res_addr;
  logic             res_wr;
  logic [7:0]       res_wdata;
  logic [4:0]       res_ts;
  logic [15:0]      idx_addr;

  // handshakes
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && s1_adv;
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign rd_en         = in_chan.valid && in_chan.ready;

  // word to read for each request
  always_comb begin
    unique case (in_chan.kind)
      KIND_REG8: rd_addr = {1'b0, in_chan.reg_select[2:1]};
      KIND_HL:   rd_addr = ENT_HL;
      KIND_IXD:  rd_addr = ENT_IX;
      KIND_IYD:  rd_addr = ENT_IY;
      KIND_PAIR: rd_addr = (in_chan.pair_select == PAIR_SP) ? ENT_SP
                                                            : {1'b0, in_chan.pair_select};
      KIND_IX:   rd_addr = ENT_IX;
      KIND_IY:   rd_addr = ENT_IY;
      default:   rd_addr = ENT_BC;
    endcase
  end

  z80inc_ram #(
    .WIDTH (RF_DW),
    .DEPTH (RF_DEPTH)
  ) u_rf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // current value of the word: unwritten reads zero, latest write wins
  assign word_ram = rd_vld_r ? ram_rdata : '0;
  assign word     = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : word_ram;
  assign idx_addr = word + {{8{s1_disp_r[7]}}, s1_disp_r};

  // the 8-bit source: register byte or memory byte
  assign inc_src = (s1_kind_r == KIND_REG8) ? (s1_rsel_r[0] ? word[7:0] : word[15:8])
                                            : s1_data_r;
  assign inc_res = inc_src + 8'd1;

  // S Z Y H X PV N C, carry kept
  assign flag_inc = {inc_res[7], (inc_res == 8'd0), inc_res[5], (inc_src[3:0] == 4'hF),
                     inc_res[3], (inc_src == 8'h7F), 1'b0, flag_r[0]};

  always_comb begin
    is8       = 1'b0;
    ram_wen   = 1'b0;
    ram_waddr = s1_addr_r;
    ram_wdata = word + 16'd1;
    res_addr  = '0;
    res_wr    = 1'b0;
    res_wdata = '0;
    res_ts    = T_REG8;
    unique case (s1_kind_r)
      KIND_REG8: begin
        is8       = (s1_rsel_r != REG_UNUSED);
        ram_wen   = (s1_rsel_r != REG_UNUSED);
        ram_wdata = s1_rsel_r[0] ? {word[15:8], inc_res} : {inc_res, word[7:0]};
      end
      KIND_HL: begin
        is8       = 1'b1;
        res_addr  = word;
        res_wr    = 1'b1;
        res_wdata = inc_res;
        res_ts    = T_HL;
      end
      KIND_IXD, KIND_IYD: begin
        // effective address also loads WZ
        is8       = 1'b1;
        ram_wen   = 1'b1;
        ram_waddr = ENT_WZ;
        ram_wdata = idx_addr;
        res_addr  = idx_addr;
        res_wr    = 1'b1;
        res_wdata = inc_res;
        res_ts    = T_INDEX;
      end
      KIND_PAIR: begin
        ram_wen = 1'b1;
        res_ts  = T_PAIR;
      end
      KIND_IX, KIND_IY: begin
        ram_wen = 1'b1;
        res_ts  = T_IDX16;
      end
      default: begin
        res_ts = T_REG8;
      end
    endcase
  end

  assign wr_en   = s1_fire && ram_wen;
  assign wr_addr = ram_waddr;
  assign wr_data = ram_wdata;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wvld_r      <= '0;
      rd_vld_r    <= 1'b0;
      fwd_vld_r   <= 1'b0;
      flag_r      <= '0;
    end else begin
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (rd_en) begin
        rd_vld_r <= wvld_r[rd_addr];
      end
      if (wr_en) begin
        wvld_r[wr_addr] <= 1'b1;
        fwd_vld_r       <= 1'b1;
      end
      if (s1_fire && is8) begin
        flag_r <= flag_inc;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_kind_r <= in_chan.kind;
      s1_rsel_r <= in_chan.reg_select;
      s1_addr_r <= rd_addr;
      s1_disp_r <= in_chan.displacement;
      s1_data_r <= in_chan.mem_data;
    end
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= wr_data;
    end
    if (s1_fire) begin
      out_addr_r  <= res_addr;
      out_wr_r    <= res_wr;
      out_wdata_r <= res_wdata;
      out_flag_r  <= is8 ? flag_inc : flag_r;
      out_ts_r    <= res_ts;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mem_address = out_addr_r;
  assign out_chan.mem_write   = out_wr_r;
  assign out_chan.write_data  = out_wdata_r;
  assign out_chan.flag_byte   = out_flag_r;
  assign out_chan.t_states    = out_ts_r;

endmodule

>>> design/z80inc_checker.sv
// port-level checks for the z80 increment unit and their binding
`include "z80_increment_unit_assert.svh"

module z80inc_checker
  import z80inc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_mem_address,
  input logic        out_mem_write,
  input logic [7:0]  out_write_data,
  input logic [4:0]  out_t_states
);

  logic write_ts_ok;
  logic idle_fields_zero;

  // only the memory forms strobe a write
  assign write_ts_ok      = (out_t_states == T_HL) || (out_t_states == T_INDEX);
  assign idle_fields_zero = (out_mem_address == 16'd0) && (out_write_data == 8'd0);

  `Z80INC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `Z80INC_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  `Z80INC_ASSERT_IMPL(a_write_timing, clk, rst_n, out_valid && out_mem_write, write_ts_ok)
  `Z80INC_ASSERT_IMPL(a_no_write_zero, clk, rst_n, out_valid && !out_mem_write, idle_fields_zero)

endmodule

bind z80_increment_unit z80inc_checker u_z80inc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_mem_address (out_chan.mem_address),
  .out_mem_write   (out_chan.mem_write),
  .out_write_data  (out_chan.write_data),
  .out_t_states    (out_chan.t_states)
);

>>> dv/z80_increment_unit_test.sv
// self-checking testbench for the z80 inc instruction unit
module z80_increment_unit_test
  import z80inc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // register slots and pair codes as the request fields encode them
  localparam logic [2:0] REG_B   = 3'd0;
  localparam logic [2:0] REG_H   = 3'd4;
  localparam logic [2:0] REG_L   = 3'd5;
  localparam logic [1:0] PAIR_BC = 2'd0;

  // flag bits of F, S Z Y H X PV N C from bit 7 down
  localparam logic [7:0] FLAG_S  = 8'h80;
  localparam logic [7:0] FLAG_Z  = 8'h40;
  localparam logic [7:0] FLAG_Y  = 8'h20;
  localparam logic [7:0] FLAG_H  = 8'h10;
  localparam logic [7:0] FLAG_X  = 8'h08;
  localparam logic [7:0] FLAG_PV = 8'h04;
  localparam logic [7:0] FLAG_C  = 8'h01;

  // receiver hold-off used to back the pipe up into the request side
  localparam int HOLD_CYCLES = 60;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        reg_select;
    logic [1:0]        pair_select;
    logic signed [7:0] displacement;
    logic [7:0]        mem_data;
  } inc_req_t;

  typedef struct packed {
    logic [15:0] mem_address;
    logic        mem_write;
    logic [7:0]  write_data;
    logic [7:0]  flag_byte;
    logic [4:0]  t_states;
  } inc_res_t;

  logic clk;
  logic rst_n;

  z80inc_in_if  in_if();
  z80inc_out_if out_if();

  z80_increment_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // architectural state as the testbench tracks it
  logic [7:0]  gpr [8];
  logic [7:0]  f_reg;
  logic [15:0] sp_reg;
  logic [15:0] ix_reg;
  logic [15:0] iy_reg;
  logic [15:0] wz_reg;

  inc_req_t req_queue [$];
  inc_res_t due_results [$];

  int  pushed;
  int  taken;
  int  errors;
  int  idle_pct;
  int  stall_pct;
  int  hold_asks;
  int  hold_done;
  int  hold_left;
  bit  in_took;

  // ------------------------------------------------------------------
  // clock and the single reset at the start
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin
    #200us;
    $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // predictor: 8-bit increment with flag update, carry kept
  // ------------------------------------------------------------------
  function automatic logic [7:0] inc_byte(logic [7:0] v);
    logic [7:0] r;
    logic [7:0] f;
    r = v + 8'd1;
    f = (f_reg & FLAG_C) | (r & (FLAG_S | FLAG_Y | FLAG_X));
    if (r == 8'h00) f |= FLAG_Z;
    // half carry out of the low nibble
    if (v[3:0] == 4'hF) f |= FLAG_H;
    // signed overflow only from 7f to 80
    if (v == 8'h7F) f |= FLAG_PV;
    f_reg = f;
    return r;
  endfunction

  // executes one inc request on the tracked state and returns its result
  function automatic inc_res_t run_inc(inc_req_t q);
    inc_res_t    r;
    logic [2:0]  hi;
    logic [2:0]  lo;
    logic [15:0] w;
    r = '0;
    r.t_states = T_REG8;
    hi = {q.pair_select, 1'b0};
    lo = {q.pair_select, 1'b1};
    case (q.kind)
      KIND_REG8: begin
        // the unused select leaves every register and F alone
        if (q.reg_select != REG_UNUSED) gpr[q.reg_select] = inc_byte(gpr[q.reg_select]);
      end
      KIND_HL: begin
        r.mem_address = {gpr[REG_H], gpr[REG_L]};
        r.write_data  = inc_byte(q.mem_data);
        r.mem_write   = 1'b1;
        r.t_states    = T_HL;
      end
      KIND_IXD, KIND_IYD: begin
        // index plus sign-extended offset, wrapping at 64k; also loads wz
        r.mem_address = ((q.kind == KIND_IXD) ? ix_reg : iy_reg)
                        + {{8{q.displacement[7]}}, q.displacement};
        wz_reg        = r.mem_address;
        r.write_data  = inc_byte(q.mem_data);
        r.mem_write   = 1'b1;
        r.t_states    = T_INDEX;
      end
      KIND_PAIR: begin
        // 16-bit forms wrap and never touch F
        if (q.pair_select == PAIR_SP) begin
          sp_reg = sp_reg + 16'd1;
        end else begin
          w = {gpr[hi], gpr[lo]} + 16'd1;
          gpr[hi] = w[15:8];
          gpr[lo] = w[7:0];
        end
        r.t_states = T_PAIR;
      end
      KIND_IX: begin
        ix_reg = ix_reg + 16'd1;
        r.t_states = T_IDX16;
      end
      KIND_IY: begin
        iy_reg = iy_reg + 16'd1;
        r.t_states = T_IDX16;
      end
      default: begin
        // unused kind: nothing changes, t-states as for a register inc
      end
    endcase
    r.flag_byte = f_reg;
    return r;
  endfunction

  task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // ------------------------------------------------------------------
  // request driver: changes at the falling edge, holds until accepted
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    inc_req_t nxt;
    if (!in_if.valid || in_took) begin
      in_took = 1'b0;
      if (rst_n && req_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = req_queue.pop_front();
        in_if.kind         <= nxt.kind;
        in_if.reg_select   <= nxt.reg_select;
        in_if.pair_select  <= nxt.pair_select;
        in_if.displacement <= nxt.displacement;
        in_if.mem_data     <= nxt.mem_data;
        in_if.valid        <= 1'b1;
      end else begin
        // idle cycle: junk on the payload, it must be ignored
        in_if.kind         <= 3'($urandom);
        in_if.reg_select   <= 3'($urandom);
        in_if.pair_select  <= 2'($urandom);
        in_if.displacement <= 8'($urandom);
        in_if.mem_data     <= 8'($urandom);
        in_if.valid        <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // result receiver: random stalls, plus a long hold-off on request
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_done != hold_asks) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // rising edge: predict accepted requests, then check accepted results
  // both in one process so a same-edge pair cannot race
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    inc_req_t q;
    inc_res_t want;
    if (rst_n && in_if.valid && in_if.ready) begin
      q.kind         = in_if.kind;
      q.reg_select   = in_if.reg_select;
      q.pair_select  = in_if.pair_select;
      q.displacement = in_if.displacement;
      q.mem_data     = in_if.mem_data;
      due_results.push_back(run_inc(q));
      taken++;
      in_took = 1'b1;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected, actual addr %h wr %b data %h f %h t %0d",
                 $time, out_if.mem_address, out_if.mem_write, out_if.write_data,
                 out_if.flag_byte, out_if.t_states);
        errors++;
      end else begin
        want = due_results.pop_front();
        check_field("mem_address", want.mem_address, out_if.mem_address);
        check_field("mem_write",   16'(want.mem_write),  16'(out_if.mem_write));
        check_field("write_data",  16'(want.write_data), 16'(out_if.write_data));
        check_field("flag_byte",   16'(want.flag_byte),  16'(out_if.flag_byte));
        check_field("t_states",    16'(want.t_states),   16'(out_if.t_states));
      end
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  function automatic inc_req_t mk_req(logic [2:0] kind, logic [2:0] rsel, logic [1:0] psel,
                                      logic [7:0] disp, logic [7:0] data);
    inc_req_t q;
    q.kind         = kind;
    q.reg_select   = rsel;
    q.pair_select  = psel;
    q.displacement = disp;
    q.mem_data     = data;
    return q;
  endfunction

  // random request over the full field ranges, the unused kind kept rare
  function automatic inc_req_t rand_req();
    inc_req_t q;
    q.kind         = ($urandom_range(0, 15) == 0) ? KIND_NONE : 3'($urandom_range(0, 6));
    q.reg_select   = 3'($urandom);
    q.pair_select  = 2'($urandom);
    q.displacement = 8'($urandom);
    // memory bytes lean toward the flag corners: 00, 0f, 7f, 80, ff
    case ($urandom_range(0, 7))
      0: q.mem_data = 8'h00;
      1: q.mem_data = 8'h0F;
      2: q.mem_data = 8'h7F;
      3: q.mem_data = 8'h80;
      4: q.mem_data = 8'hFF;
      default: q.mem_data = 8'($urandom);
    endcase
    return q;
  endfunction

  task automatic push_req(inc_req_t q);
    req_queue.push_back(q);
    pushed++;
  endtask

  task automatic wait_taken();
    wait (taken == pushed);
  endtask

  task automatic random_phase(int n, int sidle, int rstall);
    idle_pct  = sidle;
    stall_pct = rstall;
    repeat (n) push_req(rand_req());
    wait_taken();
  endtask

  initial begin
    // every block input known from time zero
    in_if.valid        = 1'b0;
    in_if.kind         = KIND_REG8;
    in_if.reg_select   = REG_B;
    in_if.pair_select  = PAIR_BC;
    in_if.displacement = 8'sd0;
    in_if.mem_data     = 8'h00;
    out_if.ready       = 1'b0;
    for (int i = 0; i < 8; i++) gpr[i] = 8'h00;
    f_reg     = 8'h00;
    sp_reg    = 16'h0000;
    ix_reg    = 16'h0000;
    iy_reg    = 16'h0000;
    wz_reg    = 16'h0000;
    pushed    = 0;
    taken     = 0;
    errors    = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_asks = 0;
    hold_done = 0;
    hold_left = 0;
    in_took   = 1'b0;

    wait (rst_n === 1'b1);

    // directed: every register select including the unused one
    for (int r = 0; r < 8; r++) push_req(mk_req(KIND_REG8, 3'(r), PAIR_BC, 8'h00, 8'h00));
    push_req(mk_req(KIND_NONE, REG_B, PAIR_BC, 8'h00, 8'hFF));
    // (hl) through the flag corners: zero, overflow, half carry, y and x bits
    push_req(mk_req(KIND_HL, REG_B, PAIR_BC, 8'h00, 8'hFF));
    push_req(mk_req(KIND_HL, REG_B, PAIR_BC, 8'h00, 8'h7F));
    push_req(mk_req(KIND_HL, REG_B, PAIR_BC, 8'h00, 8'h0F));
    push_req(mk_req(KIND_HL, REG_B, PAIR_BC, 8'h00, 8'h27));
    push_req(mk_req(KIND_HL, REG_B, PAIR_BC, 8'h00, 8'h00));
    push_req(mk_req(KIND_IX, REG_B, PAIR_BC, 8'h00, 8'h00));
    push_req(mk_req(KIND_IY, REG_B, PAIR_BC, 8'h00, 8'h00));
    // indexed with ix at both offset extremes; ix-128 wraps the address
    push_req(mk_req(KIND_IXD, REG_B, PAIR_BC, 8'h80, 8'h80));
    push_req(mk_req(KIND_IXD, REG_B, PAIR_BC, 8'h7F, 8'hFE));
    push_req(mk_req(KIND_IYD, REG_B, PAIR_BC, 8'hFF, 8'h3F));
    push_req(mk_req(KIND_IYD, REG_B, PAIR_BC, 8'h00, 8'h07));
    for (int p = 0; p < 4; p++) push_req(mk_req(KIND_PAIR, REG_B, 2'(p), 8'h00, 8'h00));
    wait_taken();

    // full rate with the receiver holding off at the start so the
    // request side backs up
    hold_asks++;
    random_phase(100, 0, 0);

    // idling phases: sender gaps, receiver stalls, both
    random_phase(130, 72, 0);
    random_phase(130, 0, 72);
    random_phase(130, 21, 21);

    // last stretch at full rate with another long hold-off
    hold_asks++;
    random_phase(40, 0, 0);

    wait (due_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> z80_increment_unit.f
+incdir+design
design/z80inc_pkg.sv
design/z80inc_if.sv
design/z80inc_ram.sv
design/z80_increment_unit.sv
design/z80inc_checker.sv
dv/z80_increment_unit_test.sv
